FILE: hdl/box_blur_3x3_wrap_assert.svh
// Assertion macros for the box blur block.
// Define NO_ASSERTIONS to compile the assertions out.
`ifndef BOX_BLUR_3X3_WRAP_ASSERT_SVH
`define BOX_BLUR_3X3_WRAP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define BBW_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("box blur assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BBW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("box blur assertion failed");

`else

`define BBW_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define BBW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/bbw_pkg.sv
package bbw_pkg;

    // Frame geometry.
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int COORD_W    = 6;
    localparam int SIZE_W     = 7;
    localparam int CHAN_W     = 8;

    // Neighbourhood sum and the reciprocal used to divide it.
    localparam int NEIGHBOURS = 9;
    localparam int SUM_W      = $clog2(NEIGHBOURS * 255 + 1);
    localparam int DIV_SHIFT  = 15;
    localparam int DIV_MULT   = ((1 << DIV_SHIFT) + NEIGHBOURS - 1) / NEIGHBOURS;
    localparam int PROD_W     = SUM_W + DIV_SHIFT;

    // Operation codes.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_BLUR = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_rgba;

    // Accumulator control from the sequencer.
    typedef struct packed {
        logic clear;
        logic add;
    } t_acc_ctrl;

    // Linear address of a pixel in the frame store.
    function automatic logic [ADDR_W-1:0] pix_addr(input logic [COORD_W-1:0] row,
                                                   input logic [COORD_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
    endfunction

    // Truncating divide by nine through a reciprocal multiply; exact for all sums.
    function automatic logic [CHAN_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [PROD_W-1:0] p;
        p = PROD_W'(s) * PROD_W'(DIV_MULT);
        return p[DIV_SHIFT +: CHAN_W];
    endfunction

endpackage

FILE: hdl/box_blur_3x3_wrap.sv
// Channel   Direction  Handshake                  Payload
// command   in         start / busy               i_func, i_col, i_row, i_in_*
// result    out        o_valid (one-cycle strobe) o_out_*, o_bad_coord
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A load writes the pixel at the edge that accepts the request.
// A blur holds busy through its read, drain and divide states, then strobes its result; the nine
// neighbour reads share the single frame memory port, one read per cycle.
// A request with a bad coordinate strobes its result in the next cycle.
// Reset is synchronous and active low; it restores width and height to 64 and
// leaves the frame store unwritten. Results cannot be held off by the receiver.
`include "box_blur_3x3_wrap_assert.svh"

module box_blur_3x3_wrap (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_func,
    input  logic [bbw_pkg::COORD_W-1:0]   i_col,
    input  logic [bbw_pkg::COORD_W-1:0]   i_row,
    input  logic [bbw_pkg::CHAN_W-1:0]    i_in_red,
    input  logic [bbw_pkg::CHAN_W-1:0]    i_in_green,
    input  logic [bbw_pkg::CHAN_W-1:0]    i_in_blue,
    input  logic [bbw_pkg::CHAN_W-1:0]    i_in_alpha,
    output logic                          o_valid,
    output logic [bbw_pkg::CHAN_W-1:0]    o_out_red,
    output logic [bbw_pkg::CHAN_W-1:0]    o_out_green,
    output logic [bbw_pkg::CHAN_W-1:0]    o_out_blue,
    output logic [bbw_pkg::CHAN_W-1:0]    o_out_alpha,
    output logic                          o_bad_coord,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bbw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bbw_pkg::SIZE_W-1:0]    i_cfg_data
);
    import bbw_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DIV   = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [SIZE_W-1:0]  r_width, r_height;
    logic [COORD_W-1:0] r_colsel [3];
    logic [COORD_W-1:0] r_rowsel [3];
    logic [1:0]         r_ci, n_ci, r_rj, n_rj;
    logic               r_rd_vld;
    logic               r_valid;
    logic               r_bad;
    t_rgba              r_out;

    logic [SIZE_W-1:0]  w_eff, h_eff;
    logic               accept, bad_now;
    logic [COORD_W-1:0] col_prev, col_next, row_prev, row_next;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    t_rgba              mem_wdata, mem_rdata, avg;
    t_acc_ctrl          acc_ctrl;

    // Effective image size, clamped to the frame store.
    assign w_eff = (32'(r_width) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : r_width;
    assign h_eff = (32'(r_height) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : r_height;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign bad_now = (SIZE_W'(i_col) >= w_eff) || (SIZE_W'(i_row) >= h_eff);

    // Toroidal neighbours of the requested pixel.
    assign col_prev = (i_col == '0) ? COORD_W'(w_eff - 1'b1) : i_col - 1'b1;
    assign col_next = (SIZE_W'(i_col) + 1'b1 >= w_eff) ? '0 : i_col + 1'b1;
    assign row_prev = (i_row == '0) ? COORD_W'(h_eff - 1'b1) : i_row - 1'b1;
    assign row_next = (SIZE_W'(i_row) + 1'b1 >= h_eff) ? '0 : i_row + 1'b1;

    // Memory port: loads write at accept, blurs read one neighbour per cycle.
    // Loads and blur reads never overlap, since requests are serialized.
    assign mem_wdata = '{alpha: i_in_alpha, blue: i_in_blue, green: i_in_green,
                         red: i_in_red};
    assign mem_we    = accept && (i_func == FUNC_LOAD) && !bad_now;
    assign mem_addr  = (r_state == S_READ) ? pix_addr(r_rowsel[r_rj], r_colsel[r_ci])
                                           : pix_addr(i_row, i_col);

    bbw_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign acc_ctrl.clear = accept;
    assign acc_ctrl.add   = r_rd_vld;

    bbw_accum u_accum (
        .i_clk   (i_clk),
        .i_ctrl  (acc_ctrl),
        .i_pixel (mem_rdata),
        .o_avg   (avg)
    );

    // Sequencer next state and neighbour counters.
    always_comb begin
        n_state = r_state;
        n_ci    = r_ci;
        n_rj    = r_rj;
        case (r_state)
            S_IDLE: begin
                n_ci = '0;
                n_rj = '0;
                if (accept && !bad_now && (i_func == FUNC_BLUR)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_rj == 2'd2) begin
                    n_rj = '0;
                    if (r_ci == 2'd2) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_ci = r_ci + 1'b1;
                    end
                end else begin
                    n_rj = r_rj + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ci     <= '0;
            r_rj     <= '0;
            r_rd_vld <= 1'b0;
            r_valid  <= 1'b0;
            r_width  <= SIZE_W'(MAX_WIDTH);
            r_height <= SIZE_W'(MAX_HEIGHT);
        end else begin
            r_state  <= n_state;
            r_ci     <= n_ci;
            r_rj     <= n_rj;
            r_rd_vld <= (r_state == S_READ);
            r_valid  <= (accept && bad_now) || (r_state == S_DIV);
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_WIDTH) begin
                    r_width <= i_cfg_data;
                end else if (i_cfg_index == CFG_HEIGHT) begin
                    r_height <= i_cfg_data;
                end
            end
        end
    end

    // Neighbour coordinates and result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_colsel[0] <= col_prev;
            r_colsel[1] <= i_col;
            r_colsel[2] <= col_next;
            r_rowsel[0] <= row_prev;
            r_rowsel[1] <= i_row;
            r_rowsel[2] <= row_next;
        end
        if (accept && bad_now) begin
            r_out <= '0;
            r_bad <= 1'b1;
        end else if (r_state == S_DIV) begin
            r_out <= avg;
            r_bad <= 1'b0;
        end
    end

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid     = r_valid;
    assign o_out_red   = r_out.red;
    assign o_out_green = r_out.green;
    assign o_out_blue  = r_out.blue;
    assign o_out_alpha = r_out.alpha;
    assign o_bad_coord = r_bad;

    // A request with a bad coordinate is answered in the next cycle.
    `BBW_ASSERT_NEXT(a_bad_answered, i_clk, i_rst_n, accept && bad_now, o_valid && o_bad_coord)
    // A good load produces no result.
    `BBW_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, mem_we, !o_valid)
    // No result appears while neighbour reads are still in flight.
    `BBW_ASSERT_SAME(a_no_early_result, i_clk, i_rst_n, r_state == S_READ, !o_valid)
    // The memory is never written while a blur is reading it.
    `BBW_ASSERT_SAME(a_no_write_in_blur, i_clk, i_rst_n, busy, !mem_we)

endmodule

FILE: hdl/bbw_store.sv
module bbw_store (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [bbw_pkg::ADDR_W-1:0] i_addr,
    input  bbw_pkg::t_rgba            i_wdata,
    output bbw_pkg::t_rgba            o_rdata
);
    import bbw_pkg::*;

    t_rgba r_mem [MAX_WIDTH * MAX_HEIGHT];
    t_rgba r_rdata;

    // Single-port frame memory with a registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/bbw_accum.sv
module bbw_accum (
    input  logic               i_clk,
    input  bbw_pkg::t_acc_ctrl i_ctrl,
    input  bbw_pkg::t_rgba     i_pixel,
    output bbw_pkg::t_rgba     o_avg
);
    import bbw_pkg::*;

    logic [SUM_W-1:0] r_sum [4];
    logic [SUM_W-1:0] n_sum [4];
    logic [CHAN_W-1:0] chan [4];

    assign chan[0] = i_pixel.red;
    assign chan[1] = i_pixel.green;
    assign chan[2] = i_pixel.blue;
    assign chan[3] = i_pixel.alpha;

    // Per-channel running sums over the neighbourhood.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (i_ctrl.clear) begin
                n_sum[k] = '0;
            end else if (i_ctrl.add) begin
                n_sum[k] = r_sum[k] + SUM_W'(chan[k]);
            end else begin
                n_sum[k] = r_sum[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_sum[k] <= n_sum[k];
        end
    end

    // Averages from the registered sums.
    assign o_avg.red   = div9(r_sum[0]);
    assign o_avg.green = div9(r_sum[1]);
    assign o_avg.blue  = div9(r_sum[2]);
    assign o_avg.alpha = div9(r_sum[3]);

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bbw_pkg::*;

    localparam int RANDOM_ITEMS   = 950;
    localparam int SETTLE_CYCLES  = 16;
    localparam int DRAIN_LIMIT    = 400;
    localparam int WATCHDOG_CYCLE = 1_000_000;

    // Register indexes that the block decodes as unused.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} t_fill;

    typedef struct packed {
        logic               func;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        t_rgba              pix;
    } t_request;

    typedef struct packed {
        t_rgba pix;
        logic  bad;
    } t_blur_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_func;
    logic [COORD_W-1:0]   i_col;
    logic [COORD_W-1:0]   i_row;
    logic [CHAN_W-1:0]    i_in_red;
    logic [CHAN_W-1:0]    i_in_green;
    logic [CHAN_W-1:0]    i_in_blue;
    logic [CHAN_W-1:0]    i_in_alpha;
    logic                 o_valid;
    logic [CHAN_W-1:0]    o_out_red;
    logic [CHAN_W-1:0]    o_out_green;
    logic [CHAN_W-1:0]    o_out_blue;
    logic [CHAN_W-1:0]    o_out_alpha;
    logic                 o_bad_coord;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [SIZE_W-1:0]    i_cfg_data;

    // Shadow copy of the block: frame contents, which entries hold data, sizes.
    t_rgba             frame_model [MAX_WIDTH*MAX_HEIGHT];
    bit                frame_written [MAX_WIDTH*MAX_HEIGHT];
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;

    t_blur_result pending_pixels[$];
    int           fail_count;
    int           req_count;
    int           burst_left;

    box_blur_3x3_wrap u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_func      (i_func),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_in_red    (i_in_red),
        .i_in_green  (i_in_green),
        .i_in_blue   (i_in_blue),
        .i_in_alpha  (i_in_alpha),
        .o_valid     (o_valid),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_alpha (o_out_alpha),
        .o_bad_coord (o_bad_coord),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Size in use: a register above the frame limit acts as the limit.
    function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] size_val,
                                               input int unsigned limit);
        return (size_val > limit) ? limit : size_val;
    endfunction

    // Neighbour coordinate one step back, in place, or one step ahead, with wrap.
    function automatic logic [COORD_W-1:0] wrap_coord(input logic [COORD_W-1:0] v,
                                                      input int unsigned size,
                                                      input int step);
        if (step < 0)
            return (v == 0) ? COORD_W'(size - 1) : v - 1'b1;
        if (step > 0)
            return (int'(v) + 1 >= size) ? '0 : v + 1'b1;
        return v;
    endfunction

    function automatic logic [CHAN_W-1:0] rand_chan();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_rgba make_pixel(input t_fill fill);
        t_rgba p;
        case (fill)
            FILL_ONES:  p = '1;
            FILL_ZEROS: p = '0;
            default: begin
                p.red   = rand_chan();
                p.green = rand_chan();
                p.blue  = rand_chan();
                p.alpha = rand_chan();
            end
        endcase
        return p;
    endfunction

    // Mostly a coordinate inside the image in use, now and then any coordinate.
    function automatic logic [COORD_W-1:0] pick_coord(input int unsigned size);
        if (size == 0 || $urandom_range(0, 9) == 0)
            return COORD_W'($urandom_range(0, 63));
        return COORD_W'($urandom_range(0, size - 1));
    endfunction

    // Works out the result of one accepted request and updates the frame copy.
    function automatic void predict_request(input t_request rq);
        int unsigned  w;
        int unsigned  h;
        int unsigned  sum [4];
        int unsigned  addr;
        t_rgba        p;
        t_blur_result res;
        w   = clamp_size(width_reg, MAX_WIDTH);
        h   = clamp_size(height_reg, MAX_HEIGHT);
        res = '0;
        if (rq.col >= w || rq.row >= h) begin
            res.bad = 1'b1;
            pending_pixels.push_back(res);
        end else if (rq.func == FUNC_LOAD) begin
            addr                = rq.row * MAX_WIDTH + rq.col;
            frame_model[addr]   = rq.pix;
            frame_written[addr] = 1'b1;
        end else begin
            sum = '{0, 0, 0, 0};
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    addr = wrap_coord(rq.row, h, dr) * MAX_WIDTH + wrap_coord(rq.col, w, dc);
                    p = frame_model[addr];
                    sum[0] += p.red;
                    sum[1] += p.green;
                    sum[2] += p.blue;
                    sum[3] += p.alpha;
                end
            end
            res.pix.red   = CHAN_W'(sum[0] / NEIGHBOURS);
            res.pix.green = CHAN_W'(sum[1] / NEIGHBOURS);
            res.pix.blue  = CHAN_W'(sum[2] / NEIGHBOURS);
            res.pix.alpha = CHAN_W'(sum[3] / NEIGHBOURS);
            pending_pixels.push_back(res);
        end
    endfunction

    // Sends one request; the sender runs in bursts with random gaps in between.
    task automatic issue_request(input t_request rq);
        @(negedge i_clk);
        i_func     = rq.func;
        i_col      = rq.col;
        i_row      = rq.row;
        i_in_red   = rq.pix.red;
        i_in_green = rq.pix.green;
        i_in_blue  = rq.pix.blue;
        i_in_alpha = rq.pix.alpha;
        start      = 1'b1;
        do @(posedge i_clk); while (busy);
        predict_request(rq);
        req_count++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge i_clk);
            start = 1'b0;
            repeat ($urandom_range(0, 14)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic load_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                              input t_rgba pix);
        t_request rq;
        rq.func = FUNC_LOAD;
        rq.col  = col;
        rq.row  = row;
        rq.pix  = pix;
        issue_request(rq);
    endtask

    // Loads every neighbour that holds no data yet, then asks for the blur.
    task automatic blur_at(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                           input t_fill fill);
        int unsigned        w;
        int unsigned        h;
        logic [COORD_W-1:0] c;
        logic [COORD_W-1:0] r;
        t_request           rq;
        w = clamp_size(width_reg, MAX_WIDTH);
        h = clamp_size(height_reg, MAX_HEIGHT);
        if (col < w && row < h) begin
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    c = wrap_coord(col, w, dc);
                    r = wrap_coord(row, h, dr);
                    if (!frame_written[r * MAX_WIDTH + c])
                        load_pixel(c, r, make_pixel(fill));
                end
            end
        end
        rq.func = FUNC_BLUR;
        rq.col  = col;
        rq.row  = row;
        rq.pix  = make_pixel(FILL_RANDOM);
        issue_request(rq);
    endtask

    task automatic idle_bus();
        if (start) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    // Waits for every expected result, then lets a possible load finish.
    task automatic wait_drained();
        int waited;
        idle_bus();
        waited = 0;
        while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_pixels.size() != 0) begin
            $error("%0d expected results never arrived", pending_pixels.size());
            fail_count++;
            pending_pixels.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [SIZE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_WIDTH)
            width_reg = val;
        else if (idx == CFG_HEIGHT)
            height_reg = val;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_image_size(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        wait_drained();
        write_size_reg(CFG_WIDTH, w);
        write_size_reg(CFG_HEIGHT, h);
    endtask

    // Reset sizes: blur at both corners so the neighbourhood wraps both ways.
    task automatic test_corner_wrap();
        blur_at(6'd0, 6'd0, FILL_ONES);
        blur_at(6'd63, 6'd63, FILL_ZEROS);
    endtask

    // Coordinates outside the image in use, for load and blur.
    task automatic test_bad_coords();
        set_image_size(7'd5, 7'd7);
        load_pixel(6'd5, 6'd0, make_pixel(FILL_ONES));
        blur_at(6'd0, 6'd7, FILL_RANDOM);
        load_pixel(6'd63, 6'd63, make_pixel(FILL_ONES));
    endtask

    // With a size of one, every neighbour on that axis is the centre.
    task automatic test_unit_size();
        set_image_size(7'd1, 7'd1);
        blur_at(6'd0, 6'd0, FILL_RANDOM);
        set_image_size(7'd1, 7'd64);
        blur_at(6'd0, 6'd63, FILL_RANDOM);
    endtask

    // A size of zero makes every coordinate bad.
    task automatic test_zero_size();
        set_image_size(7'd0, 7'd64);
        load_pixel(6'd0, 6'd0, make_pixel(FILL_RANDOM));
        blur_at(6'd0, 6'd0, FILL_RANDOM);
        set_image_size(7'd64, 7'd0);
        blur_at(6'd0, 6'd0, FILL_RANDOM);
    endtask

    // Oversized registers act as the frame limit; spare indexes change nothing.
    task automatic test_oversize_and_spare();
        set_image_size(7'd127, 7'd65);
        write_size_reg(CFG_SPARE_2, SIZE_W'($urandom_range(0, 127)));
        write_size_reg(CFG_SPARE_3, SIZE_W'($urandom_range(0, 127)));
        blur_at(6'd63, 6'd63, FILL_RANDOM);
        blur_at(6'd0, 6'd0, FILL_RANDOM);
    endtask

    // Phases of random loads and blurs over a series of image sizes.
    task automatic test_random_traffic();
        int unsigned size_table [10][2] = '{'{64, 64}, '{1, 1}, '{2, 3}, '{64, 1},
                                           '{1, 64}, '{0, 9}, '{127, 127}, '{7, 0},
                                           '{2, 2}, '{33, 17}};
        int unsigned w;
        int unsigned h;
        int          phase;
        int          first_item;
        int          phase_end;
        int          sel;
        first_item = req_count;
        phase      = 0;
        while (req_count - first_item < RANDOM_ITEMS) begin
            if (phase < 10) begin
                set_image_size(SIZE_W'(size_table[phase][0]), SIZE_W'(size_table[phase][1]));
            end else if ($urandom_range(0, 2) == 0) begin
                set_image_size(SIZE_W'($urandom_range(0, 127)), SIZE_W'($urandom_range(0, 127)));
            end else begin
                set_image_size(SIZE_W'($urandom_range(1, 16)), SIZE_W'($urandom_range(1, 16)));
            end
            phase++;
            w = clamp_size(width_reg, MAX_WIDTH);
            h = clamp_size(height_reg, MAX_HEIGHT);
            phase_end = req_count + ((w == 0 || h == 0) ? $urandom_range(10, 20)
                                                        : $urandom_range(60, 140));
            while (req_count < phase_end) begin
                sel = $urandom_range(0, 99);
                if (sel < 55)
                    blur_at(pick_coord(w), pick_coord(h), FILL_RANDOM);
                else if (sel < 92)
                    load_pixel(pick_coord(w), pick_coord(h), make_pixel(FILL_RANDOM));
                else
                    blur_at(COORD_W'($urandom_range(0, 63)), COORD_W'($urandom_range(0, 63)),
                            FILL_RANDOM);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [CHAN_W-1:0] exp_val,
                               input logic [CHAN_W-1:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            fail_count++;
        end
    endtask

    // Each result strobe is compared with the oldest expected result.
    always @(posedge i_clk) begin : check_result
        t_blur_result exp_res;
        if (i_rst_n && o_valid) begin
            if (pending_pixels.size() == 0) begin
                $error("result strobe with no request waiting for one");
                fail_count++;
            end else begin
                exp_res = pending_pixels.pop_front();
                check_field("out_red", exp_res.pix.red, o_out_red);
                check_field("out_green", exp_res.pix.green, o_out_green);
                check_field("out_blue", exp_res.pix.blue, o_out_blue);
                check_field("out_alpha", exp_res.pix.alpha, o_out_alpha);
                check_field("bad_coord", CHAN_W'(exp_res.bad), CHAN_W'(o_bad_coord));
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        repeat (WATCHDOG_CYCLE) @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // Reset, then run the tests in turn.
    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_func      = FUNC_LOAD;
        i_col       = '0;
        i_row       = '0;
        i_in_red    = '0;
        i_in_green  = '0;
        i_in_blue   = '0;
        i_in_alpha  = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_WIDTH;
        i_cfg_data  = '0;
        width_reg   = SIZE_W'(MAX_WIDTH);
        height_reg  = SIZE_W'(MAX_HEIGHT);
        fail_count  = 0;
        req_count   = 0;
        burst_left  = 0;
        foreach (frame_written[i]) begin
            frame_written[i] = 1'b0;
            frame_model[i]   = '0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_corner_wrap();
        test_bad_coords();
        test_unit_size();
        test_zero_size();
        test_oversize_and_spare();
        test_random_traffic();
        wait_drained();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/bbw_pkg.sv
hdl/bbw_store.sv
hdl/bbw_accum.sv
hdl/box_blur_3x3_wrap.sv
tb/sv/tb_top.sv
